// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// ----- hdl/deblk_pkg.sv -----
`default_nettype none

package deblk_pkg;

   localparam int STRENGTH_W = 3;

   typedef logic [STRENGTH_W-1:0] strength_type;

   // filter strengths, from pass-through up to the six-pixel rewrite
   localparam strength_type STR_OFF  = 3'd0;
   localparam strength_type STR_WEAK = 3'd1;
   localparam strength_type STR_EDGE = 3'd2;
   localparam strength_type STR_MID  = 3'd3;
   localparam strength_type STR_FULL = 3'd4;

endpackage

`default_nettype wire

// ----- hdl/deblk_channel_if.sv -----
`default_nettype none

// request channel: one line of six pixels with thresholds and flags
interface deblk_req_if #(
   parameter int PIXEL_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] far_left;
   logic [PIXEL_BITS-1:0] mid_left;
   logic [PIXEL_BITS-1:0] near_left;
   logic [PIXEL_BITS-1:0] near_right;
   logic [PIXEL_BITS-1:0] mid_right;
   logic [PIXEL_BITS-1:0] far_right;
   logic [8:0]            alpha_threshold;
   logic [6:0]            beta_threshold;
   logic                  line_enable;
   logic                  is_chroma;

   modport source (
      output valid, far_left, mid_left, near_left, near_right, mid_right, far_right,
      output alpha_threshold, beta_threshold, line_enable, is_chroma,
      input  ready
   );
   modport sink (
      input  valid, far_left, mid_left, near_left, near_right, mid_right, far_right,
      input  alpha_threshold, beta_threshold, line_enable, is_chroma,
      output ready
   );
endinterface

// response channel: filtered line and the strength applied
interface deblk_rsp_if #(
   parameter int PIXEL_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] out_far_left;
   logic [PIXEL_BITS-1:0] out_mid_left;
   logic [PIXEL_BITS-1:0] out_near_left;
   logic [PIXEL_BITS-1:0] out_near_right;
   logic [PIXEL_BITS-1:0] out_mid_right;
   logic [PIXEL_BITS-1:0] out_far_right;
   logic [2:0]            strength;

   modport source (
      output valid, out_far_left, out_mid_left, out_near_left,
      output out_near_right, out_mid_right, out_far_right, strength,
      input  ready
   );
   modport sink (
      input  valid, out_far_left, out_mid_left, out_near_left,
      input  out_near_right, out_mid_right, out_far_right, strength,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/deblock_edge_line_filter_core.sv -----
`default_nettype none

// channel | modport      | payload
// --------+--------------+-----------------------------------------------
// req_    | sink         | six pixels, alpha, beta, line_enable, is_chroma
// rsp_    | source       | six filtered pixels, strength
//
// two register stages: request register, then response register; the
// strength decision and the pixel rewrite sit between them as combinational logic.
// one line per cycle sustained while the response side is ready.
// reset (synchronous, active high) clears both valid flags only.
// a stalled response holds; a new request is taken while the request stage is
// empty or can move into a free or draining response register.

module deblock_edge_line_filter_core #(
   parameter int PIXEL_BITS = 10
) (
   input  wire logic  clock,
   input  wire logic  reset,
   deblk_req_if.sink   req_chan,
   deblk_rsp_if.source rsp_chan
);
   import deblk_pkg::*;

   logic                  stage_valid_ff;
   logic                  rsp_valid_ff;
   logic                  advance;
   logic                  req_take;

   logic [PIXEL_BITS-1:0] l2_ff, l1_ff, l0_ff, r0_ff, r1_ff, r2_ff;
   logic [8:0]            alpha_ff;
   logic [6:0]            beta_ff;
   logic                  enable_ff;
   logic                  chroma_ff;

   strength_type          strength_in;
   logic [PIXEL_BITS-1:0] o_l2_in, o_l1_in, o_l0_in, o_r0_in, o_r1_in, o_r2_in;

   logic [PIXEL_BITS-1:0] o_l2_ff, o_l1_ff, o_l0_ff, o_r0_ff, o_r1_ff, o_r2_ff;
   strength_type          strength_ff;

   // pipeline flow control
   assign advance        = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            stage_valid_ff <= 1'b1;
         end else if (advance) begin
            stage_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (req_take) begin
         l2_ff     <= req_chan.far_left;
         l1_ff     <= req_chan.mid_left;
         l0_ff     <= req_chan.near_left;
         r0_ff     <= req_chan.near_right;
         r1_ff     <= req_chan.mid_right;
         r2_ff     <= req_chan.far_right;
         alpha_ff  <= req_chan.alpha_threshold;
         beta_ff   <= req_chan.beta_threshold;
         enable_ff <= req_chan.line_enable;
         chroma_ff <= req_chan.is_chroma;
      end
   end

   // strength decision
   deblk_strength #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_strength (
      .l2          (l2_ff),
      .l1          (l1_ff),
      .l0          (l0_ff),
      .r0          (r0_ff),
      .r1          (r1_ff),
      .r2          (r2_ff),
      .alpha       (alpha_ff),
      .beta        (beta_ff),
      .line_enable (enable_ff),
      .is_chroma   (chroma_ff),
      .strength    (strength_in)
   );

   // pixel rewrite
   deblk_filter #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_filter (
      .l2       (l2_ff),
      .l1       (l1_ff),
      .l0       (l0_ff),
      .r0       (r0_ff),
      .r1       (r1_ff),
      .r2       (r2_ff),
      .strength (strength_in),
      .o_l2     (o_l2_in),
      .o_l1     (o_l1_in),
      .o_l0     (o_l0_in),
      .o_r0     (o_r0_in),
      .o_r1     (o_r1_in),
      .o_r2     (o_r2_in)
   );

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         o_l2_ff     <= o_l2_in;
         o_l1_ff     <= o_l1_in;
         o_l0_ff     <= o_l0_in;
         o_r0_ff     <= o_r0_in;
         o_r1_ff     <= o_r1_in;
         o_r2_ff     <= o_r2_in;
         strength_ff <= strength_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_far_left   = o_l2_ff;
   assign rsp_chan.out_mid_left   = o_l1_ff;
   assign rsp_chan.out_near_left  = o_l0_ff;
   assign rsp_chan.out_near_right = o_r0_ff;
   assign rsp_chan.out_mid_right  = o_r1_ff;
   assign rsp_chan.out_far_right  = o_r2_ff;
   assign rsp_chan.strength       = strength_ff;

endmodule

`default_nettype wire

// ----- hdl/deblk_strength.sv -----
`default_nettype none

module deblk_strength #(
   parameter int PIXEL_BITS = 10
) (
   input  wire logic [PIXEL_BITS-1:0] l2,
   input  wire logic [PIXEL_BITS-1:0] l1,
   input  wire logic [PIXEL_BITS-1:0] l0,
   input  wire logic [PIXEL_BITS-1:0] r0,
   input  wire logic [PIXEL_BITS-1:0] r1,
   input  wire logic [PIXEL_BITS-1:0] r2,
   input  wire logic [8:0]            alpha,
   input  wire logic [6:0]            beta,
   input  wire logic                  line_enable,
   input  wire logic                  is_chroma,
   output deblk_pkg::strength_type    strength
);
   import deblk_pkg::*;

   localparam int CW = (PIXEL_BITS > 9) ? PIXEL_BITS : 9;

   function automatic logic [PIXEL_BITS-1:0] abs_diff(
      input logic [PIXEL_BITS-1:0] a,
      input logic [PIXEL_BITS-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [PIXEL_BITS-1:0] step;
   logic [PIXEL_BITS-1:0] beta_x;
   logic                  step_ok;
   logic [1:0]            flat_left;
   logic [1:0]            flat_right;
   logic [2:0]            flat_sum;
   logic                  same;
   strength_type          base;

   // edge step must lie strictly between one and alpha
   assign step    = abs_diff(r0, l0);
   assign beta_x  = PIXEL_BITS'(beta);
   assign step_ok = line_enable && (CW'(step) < CW'(alpha)) && (step > PIXEL_BITS'(1));

   // side flatness against beta
   assign flat_left  = {abs_diff(l1, l0) < beta_x, abs_diff(l2, l0) < beta_x};
   assign flat_right = {abs_diff(r0, r1) < beta_x, abs_diff(r0, r2) < beta_x};
   assign flat_sum   = {1'b0, flat_left} + {1'b0, flat_right};
   assign same       = (r1 == r0) && (l0 == l1);

   // strength from the flatness sum
   always_comb begin
      case (flat_sum)
         3'd6:    base = same ? STR_FULL : STR_MID;
         3'd5:    base = same ? STR_MID : STR_EDGE;
         3'd4:    base = (flat_left == 2'd2) ? STR_EDGE : STR_WEAK;
         3'd3:    base = (abs_diff(l1, r1) < beta_x) ? STR_WEAK : STR_OFF;
         default: base = STR_OFF;
      endcase
   end

   // chroma drops a nonzero strength by one
   always_comb begin
      if (!step_ok) begin
         strength = STR_OFF;
      end else if (is_chroma && (base != STR_OFF)) begin
         strength = base - STR_WEAK;
      end else begin
         strength = base;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/deblk_filter.sv -----
`default_nettype none

module deblk_filter #(
   parameter int PIXEL_BITS = 10
) (
   input  wire logic [PIXEL_BITS-1:0] l2,
   input  wire logic [PIXEL_BITS-1:0] l1,
   input  wire logic [PIXEL_BITS-1:0] l0,
   input  wire logic [PIXEL_BITS-1:0] r0,
   input  wire logic [PIXEL_BITS-1:0] r1,
   input  wire logic [PIXEL_BITS-1:0] r2,
   input  deblk_pkg::strength_type    strength,
   output logic      [PIXEL_BITS-1:0] o_l2,
   output logic      [PIXEL_BITS-1:0] o_l1,
   output logic      [PIXEL_BITS-1:0] o_l0,
   output logic      [PIXEL_BITS-1:0] o_r0,
   output logic      [PIXEL_BITS-1:0] o_r1,
   output logic      [PIXEL_BITS-1:0] o_r2
);
   import deblk_pkg::*;

   // weights sum to at most 32, plus rounding
   localparam int SW = PIXEL_BITS + 6;

   logic [SW-1:0] xl2, xl1, xl0, xr0, xr1, xr2;
   logic [SW-1:0] s4_l0, s4_l1, s4_l2, s4_r0, s4_r1, s4_r2;
   logic [SW-1:0] s3_l0, s3_l1, s3_r0, s3_r1;
   logic [SW-1:0] s2_l0, s2_r0;
   logic [SW-1:0] s1_l0, s1_r0;

   assign xl2 = SW'(l2);
   assign xl1 = SW'(l1);
   assign xl0 = SW'(l0);
   assign xr0 = SW'(r0);
   assign xr1 = SW'(r1);
   assign xr2 = SW'(r2);

   // six-pixel rewrite
   assign s4_l0 = xl0 * SW'(9) + xl2 * SW'(9) + xr0 * SW'(8) + xr2 * SW'(6) + SW'(16);
   assign s4_l1 = xl0 * SW'(7) + xl2 * SW'(6) + xr0 * SW'(3) + SW'(8);
   assign s4_l2 = xl0 * SW'(4) + xl2 * SW'(3) + xr0 + SW'(4);
   assign s4_r0 = xr0 * SW'(9) + xr2 * SW'(9) + xl0 * SW'(8) + xl2 * SW'(6) + SW'(16);
   assign s4_r1 = xr0 * SW'(7) + xr2 * SW'(6) + xl0 * SW'(3) + SW'(8);
   assign s4_r2 = xr0 * SW'(4) + xr2 * SW'(3) + xl0 + SW'(4);

   // four-pixel rewrite
   assign s3_l0 = xl2 + xl1 * SW'(4) + xl0 * SW'(6) + xr0 * SW'(4) + xr1 + SW'(8);
   assign s3_r0 = xl1 + xl0 * SW'(4) + xr0 * SW'(6) + xr1 * SW'(4) + xr2 + SW'(8);
   assign s3_l1 = xl2 * SW'(3) + xl1 * SW'(8) + xl0 * SW'(4) + xr0 + SW'(8);
   assign s3_r1 = xr2 * SW'(3) + xr1 * SW'(8) + xr0 * SW'(4) + xl0 + SW'(8);

   // edge pair rewrite
   assign s2_l0 = xl1 * SW'(3) + xl0 * SW'(10) + xr0 * SW'(3) + SW'(8);
   assign s2_r0 = xl0 * SW'(3) + xr0 * SW'(10) + xr1 * SW'(3) + SW'(8);

   // 3:1 blend of the edge pair
   assign s1_l0 = xl0 * SW'(3) + xr0 + SW'(2);
   assign s1_r0 = xr0 * SW'(3) + xl0 + SW'(2);

   // pick the rewrite by strength
   always_comb begin
      o_l2 = l2;
      o_l1 = l1;
      o_l0 = l0;
      o_r0 = r0;
      o_r1 = r1;
      o_r2 = r2;
      case (strength)
         STR_FULL: begin
            o_l0 = s4_l0[PIXEL_BITS+4:5];
            o_l1 = s4_l1[PIXEL_BITS+3:4];
            o_l2 = s4_l2[PIXEL_BITS+2:3];
            o_r0 = s4_r0[PIXEL_BITS+4:5];
            o_r1 = s4_r1[PIXEL_BITS+3:4];
            o_r2 = s4_r2[PIXEL_BITS+2:3];
         end
         STR_MID: begin
            o_l0 = s3_l0[PIXEL_BITS+3:4];
            o_r0 = s3_r0[PIXEL_BITS+3:4];
            o_l1 = s3_l1[PIXEL_BITS+3:4];
            o_r1 = s3_r1[PIXEL_BITS+3:4];
         end
         STR_EDGE: begin
            o_l0 = s2_l0[PIXEL_BITS+3:4];
            o_r0 = s2_r0[PIXEL_BITS+3:4];
         end
         STR_WEAK: begin
            o_l0 = s1_l0[PIXEL_BITS+1:2];
            o_r0 = s1_r0[PIXEL_BITS+1:2];
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/deblk_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module deblk_checker #(
   parameter int PIXEL_BITS = 10
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [PIXEL_BITS-1:0] rsp_near_left,
   input wire logic [PIXEL_BITS-1:0] rsp_near_right,
   input wire logic [2:0]            rsp_strength
);

   // a stalled response keeps its valid
   `ASSERT_ALWAYS(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // a stalled response keeps its payload
   `ASSERT_ALWAYS(a_rsp_stable, clock, reset,
      rsp_valid && !rsp_ready |=> $stable({rsp_near_left, rsp_near_right, rsp_strength}))

   // request side only blocks when the response side is full and stalled
   `ASSERT_ALWAYS(a_req_block, clock, reset, !req_ready |-> rsp_valid && !rsp_ready)

   // an accepted request passes the request and response registers and shows as a valid response when unstalled
   `ASSERT_ALWAYS(a_latency, clock, reset, req_valid && req_ready ##1 rsp_ready |=> rsp_valid)

   // strength never exceeds the full rewrite
   `ASSERT_NEVER(a_strength_range, clock, reset, rsp_valid && (rsp_strength > 3'd4))

endmodule

bind deblock_edge_line_filter_core deblk_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_deblk_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_near_left  (rsp_chan.out_near_left),
   .rsp_near_right (rsp_chan.out_near_right),
   .rsp_strength   (rsp_chan.strength)
);

`default_nettype wire

// ----- dv/tb_deblock_edge_line_filter_core.sv -----
`timescale 1ns / 1ps

module tb_deblock_edge_line_filter_core;
   import deblk_pkg::*;

   localparam int PIXEL_BITS = 10;
   localparam int RANDOM_LINES = 1000;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   // one line across the edge as it goes into the filter
   typedef struct packed {
      logic [PIXEL_BITS-1:0] far_left;
      logic [PIXEL_BITS-1:0] mid_left;
      logic [PIXEL_BITS-1:0] near_left;
      logic [PIXEL_BITS-1:0] near_right;
      logic [PIXEL_BITS-1:0] mid_right;
      logic [PIXEL_BITS-1:0] far_right;
      logic [8:0]            alpha_threshold;
      logic [6:0]            beta_threshold;
      logic                  line_enable;
      logic                  is_chroma;
   } edge_line_type;

   // filtered line with the strength that was applied
   typedef struct packed {
      logic [PIXEL_BITS-1:0] out_far_left;
      logic [PIXEL_BITS-1:0] out_mid_left;
      logic [PIXEL_BITS-1:0] out_near_left;
      logic [PIXEL_BITS-1:0] out_near_right;
      logic [PIXEL_BITS-1:0] out_mid_right;
      logic [PIXEL_BITS-1:0] out_far_right;
      strength_type          strength;
   } filtered_line_type;

   function automatic int unsigned pix_diff(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   // expected filter output for one line
   function automatic filtered_line_type filter_line(edge_line_type ln);
      int unsigned l2, l1, l0, r0, r1, r2;
      int unsigned alpha, beta, step, fl, fr;
      bit same;
      strength_type st;
      filtered_line_type res;
      l2 = 32'(ln.far_left);
      l1 = 32'(ln.mid_left);
      l0 = 32'(ln.near_left);
      r0 = 32'(ln.near_right);
      r1 = 32'(ln.mid_right);
      r2 = 32'(ln.far_right);
      alpha = 32'(ln.alpha_threshold);
      beta = 32'(ln.beta_threshold);
      step = pix_diff(r0, l0);
      res.out_far_left = ln.far_left;
      res.out_mid_left = ln.mid_left;
      res.out_near_left = ln.near_left;
      res.out_near_right = ln.near_right;
      res.out_mid_right = ln.mid_right;
      res.out_far_right = ln.far_right;
      st = STR_OFF;
      if (ln.line_enable && step < alpha && step > 1) begin
         // side flatness decides the strength
         fl = (pix_diff(l1, l0) < beta ? 2 : 0) + (pix_diff(l2, l0) < beta ? 1 : 0);
         fr = (pix_diff(r0, r1) < beta ? 2 : 0) + (pix_diff(r0, r2) < beta ? 1 : 0);
         same = (r1 == r0) && (l0 == l1);
         case (fl + fr)
            6: st = same ? STR_FULL : STR_MID;
            5: st = same ? STR_MID : STR_EDGE;
            4: st = (fl == 2) ? STR_EDGE : STR_WEAK;
            3: st = (pix_diff(l1, r1) < beta) ? STR_WEAK : STR_OFF;
            default: st = STR_OFF;
         endcase
         if (ln.is_chroma && st != STR_OFF)
            st = st - 1'b1;
         // weighted-average rewrite for the chosen strength
         case (st)
            STR_FULL: begin
               res.out_near_left = PIXEL_BITS'((9*l0 + 9*l2 + 8*r0 + 6*r2 + 16) >> 5);
               res.out_mid_left = PIXEL_BITS'((7*l0 + 6*l2 + 3*r0 + 8) >> 4);
               res.out_far_left = PIXEL_BITS'((4*l0 + 3*l2 + r0 + 4) >> 3);
               res.out_near_right = PIXEL_BITS'((9*r0 + 9*r2 + 8*l0 + 6*l2 + 16) >> 5);
               res.out_mid_right = PIXEL_BITS'((7*r0 + 6*r2 + 3*l0 + 8) >> 4);
               res.out_far_right = PIXEL_BITS'((4*r0 + 3*r2 + l0 + 4) >> 3);
            end
            STR_MID: begin
               res.out_near_left = PIXEL_BITS'((l2 + 4*l1 + 6*l0 + 4*r0 + r1 + 8) >> 4);
               res.out_near_right = PIXEL_BITS'((l1 + 4*l0 + 6*r0 + 4*r1 + r2 + 8) >> 4);
               res.out_mid_left = PIXEL_BITS'((3*l2 + 8*l1 + 4*l0 + r0 + 8) >> 4);
               res.out_mid_right = PIXEL_BITS'((3*r2 + 8*r1 + 4*r0 + l0 + 8) >> 4);
            end
            STR_EDGE: begin
               res.out_near_left = PIXEL_BITS'((3*l1 + 10*l0 + 3*r0 + 8) >> 4);
               res.out_near_right = PIXEL_BITS'((3*l0 + 10*r0 + 3*r1 + 8) >> 4);
            end
            STR_WEAK: begin
               res.out_near_left = PIXEL_BITS'((3*l0 + r0 + 2) >> 2);
               res.out_near_right = PIXEL_BITS'((3*r0 + l0 + 2) >> 2);
            end
            default: ;
         endcase
      end
      res.strength = st;
      return res;
   endfunction

   // expected filtered lines in request order
   class deblock_scoreboard_type;
      filtered_line_type pending_lines[$];
      int errors;
      int checked;
      int strength_seen[5];

      function new();
         errors = 0;
         checked = 0;
         foreach (strength_seen[i]) strength_seen[i] = 0;
      endfunction

      function int pending();
         return pending_lines.size();
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      function void note_request(edge_line_type ln);
         pending_lines.push_back(filter_line(ln));
      endfunction

      task compare_field(string name, int got, int want);
         if (got != want)
            report_mismatch($sformatf("line %0d %s got %0d want %0d", checked, name, got, want));
      endtask

      task check_result(filtered_line_type got);
         filtered_line_type want;
         if (pending_lines.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_lines.pop_front();
            compare_field("out_far_left", int'(got.out_far_left), int'(want.out_far_left));
            compare_field("out_mid_left", int'(got.out_mid_left), int'(want.out_mid_left));
            compare_field("out_near_left", int'(got.out_near_left),
                          int'(want.out_near_left));
            compare_field("out_near_right", int'(got.out_near_right),
                          int'(want.out_near_right));
            compare_field("out_mid_right", int'(got.out_mid_right),
                          int'(want.out_mid_right));
            compare_field("out_far_right", int'(got.out_far_right),
                          int'(want.out_far_right));
            compare_field("strength", int'(got.strength), int'(want.strength));
            if (want.strength <= STR_FULL)
               strength_seen[want.strength]++;
         end
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   int cycle_count = 0;
   int lines_sent;
   bit sender_burst;
   bit receiver_burst;
   deblock_scoreboard_type sb;

   deblk_req_if #(.PIXEL_BITS(PIXEL_BITS)) req_if ();
   deblk_rsp_if #(.PIXEL_BITS(PIXEL_BITS)) rsp_if ();

   deblock_edge_line_filter_core #(
      .PIXEL_BITS(PIXEL_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // send one request, with a random gap ahead of it outside bursts
   task automatic send_line(input edge_line_type ln);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.far_left <= ln.far_left;
      req_if.mid_left <= ln.mid_left;
      req_if.near_left <= ln.near_left;
      req_if.near_right <= ln.near_right;
      req_if.mid_right <= ln.mid_right;
      req_if.far_right <= ln.far_right;
      req_if.alpha_threshold <= ln.alpha_threshold;
      req_if.beta_threshold <= ln.beta_threshold;
      req_if.line_enable <= ln.line_enable;
      req_if.is_chroma <= ln.is_chroma;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(ln);
      lines_sent++;
   endtask

   task automatic send_directed(input int l2, input int l1, input int l0, input int r0,
                                input int r1, input int r2, input int alpha, input int beta,
                                input bit en, input bit chroma);
      edge_line_type ln;
      ln.far_left = PIXEL_BITS'(l2);
      ln.mid_left = PIXEL_BITS'(l1);
      ln.near_left = PIXEL_BITS'(l0);
      ln.near_right = PIXEL_BITS'(r0);
      ln.mid_right = PIXEL_BITS'(r1);
      ln.far_right = PIXEL_BITS'(r2);
      ln.alpha_threshold = 9'(alpha);
      ln.beta_threshold = 7'(beta);
      ln.line_enable = en;
      ln.is_chroma = chroma;
      send_line(ln);
   endtask

   // hold the request side idle until every response is back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
   endtask

   function automatic logic [PIXEL_BITS-1:0] clamp_pixel(int v);
      if (v < 0) return '0;
      if (v > 1023) return 10'd1023;
      return v[PIXEL_BITS-1:0];
   endfunction

   // pixel near a base value, often right at the beta boundary
   function automatic logic [PIXEL_BITS-1:0] near_pixel(int base, int beta);
      int off;
      case ($urandom_range(0, 4))
         0: off = 0;
         1: off = beta;
         2: off = (beta > 0) ? beta - 1 : 0;
         default: off = $urandom_range(0, 2 * beta + 2);
      endcase
      if ($urandom_range(0, 1)) off = -off;
      return clamp_pixel(base + off);
   endfunction

   // random line: mostly plausible edges, some raw noise
   function automatic edge_line_type random_line();
      edge_line_type ln;
      int alpha, beta, step, l0, r0;
      if ($urandom_range(0, 3) == 0) begin
         ln.far_left = PIXEL_BITS'($urandom_range(0, 1023));
         ln.mid_left = PIXEL_BITS'($urandom_range(0, 1023));
         ln.near_left = PIXEL_BITS'($urandom_range(0, 1023));
         ln.near_right = PIXEL_BITS'($urandom_range(0, 1023));
         ln.mid_right = PIXEL_BITS'($urandom_range(0, 1023));
         ln.far_right = PIXEL_BITS'($urandom_range(0, 1023));
         ln.alpha_threshold = 9'($urandom_range(0, 511));
         ln.beta_threshold = 7'($urandom_range(0, 127));
         ln.line_enable = 1'($urandom_range(0, 1));
         ln.is_chroma = 1'($urandom_range(0, 1));
      end else begin
         alpha = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 256);
         beta = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 108);
         l0 = $urandom_range(0, 1023);
         step = $urandom_range(0, alpha + 2);
         r0 = 32'(clamp_pixel($urandom_range(0, 1) ? l0 - step : l0 + step));
         ln.near_left = PIXEL_BITS'(l0);
         ln.near_right = PIXEL_BITS'(r0);
         ln.mid_left = near_pixel(l0, beta);
         ln.far_left = near_pixel(l0, beta);
         ln.mid_right = near_pixel(r0, beta);
         ln.far_right = near_pixel(r0, beta);
         ln.alpha_threshold = 9'(alpha);
         ln.beta_threshold = 7'(beta);
         ln.line_enable = ($urandom_range(0, 9) != 0);
         ln.is_chroma = 1'($urandom_range(0, 1));
      end
      return ln;
   endfunction

   // response side: random stalls, with stretches of none
   initial begin
      int stall;
      int taken;
      filtered_line_type got;
      taken = 0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 64 == 0)
            receiver_burst = ($urandom_range(0, 3) == 0);
         stall = receiver_burst ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.out_far_left = rsp_if.out_far_left;
         got.out_mid_left = rsp_if.out_mid_left;
         got.out_near_left = rsp_if.out_near_left;
         got.out_near_right = rsp_if.out_near_right;
         got.out_mid_right = rsp_if.out_mid_right;
         got.out_far_right = rsp_if.out_far_right;
         got.strength = rsp_if.strength;
         sb.check_result(got);
         taken++;
      end
   end

   // main sequence
   initial begin
      sb = new();
      lines_sent = 0;
      sender_burst = 1'b0;
      receiver_burst = 1'b0;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.far_left <= '0;
      req_if.mid_left <= '0;
      req_if.near_left <= '0;
      req_if.near_right <= '0;
      req_if.mid_right <= '0;
      req_if.far_right <= '0;
      req_if.alpha_threshold <= '0;
      req_if.beta_threshold <= '0;
      req_if.line_enable <= 1'b0;
      req_if.is_chroma <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // pass-through cases: disabled, no step, step of one, step at alpha, zero alpha, zero beta
      send_directed(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_directed(1023, 1023, 1023, 1023, 1023, 1023, 511, 127, 1, 0);
      send_directed(100, 100, 100, 101, 101, 101, 20, 5, 1, 0);
      send_directed(100, 100, 100, 120, 120, 120, 20, 5, 1, 0);
      send_directed(100, 100, 100, 110, 110, 110, 20, 5, 0, 0);
      send_directed(100, 100, 100, 110, 110, 110, 0, 5, 1, 0);
      send_directed(100, 100, 100, 110, 110, 110, 20, 0, 1, 0);
      // smallest step that filters
      send_directed(100, 100, 100, 102, 102, 102, 3, 5, 1, 0);
      // both sides flat and equal, luma and chroma
      send_directed(100, 100, 100, 110, 110, 110, 20, 5, 1, 0);
      send_directed(100, 100, 100, 110, 110, 110, 20, 5, 1, 1);
      // both sides flat, not equal
      send_directed(100, 101, 100, 110, 110, 110, 20, 5, 1, 0);
      send_directed(100, 101, 100, 110, 110, 110, 20, 5, 1, 1);
      // one far pixel rough
      send_directed(90, 100, 100, 110, 110, 110, 20, 5, 1, 0);
      send_directed(90, 101, 100, 110, 110, 110, 20, 5, 1, 0);
      // both far pixels rough
      send_directed(90, 100, 100, 110, 110, 120, 20, 5, 1, 0);
      // right mid pixel rough
      send_directed(100, 100, 100, 110, 104, 110, 20, 5, 1, 0);
      send_directed(100, 100, 100, 110, 104, 110, 20, 5, 1, 1);
      // flatness sum of three, cross check passes then fails
      send_directed(90, 100, 100, 110, 104, 110, 20, 5, 1, 0);
      send_directed(90, 100, 100, 110, 120, 110, 20, 5, 1, 0);
      // pixel range extremes
      send_directed(0, 0, 0, 2, 2, 2, 3, 1, 1, 0);
      send_directed(1023, 1023, 1023, 1000, 1000, 1000, 256, 108, 1, 0);
      send_directed(0, 1023, 512, 511, 1023, 0, 511, 127, 1, 1);
      send_directed(1023, 0, 1023, 0, 1023, 0, 256, 108, 1, 0);
      drain_results();

      // random lines
      for (int n = 0; n < RANDOM_LINES; n++) begin
         if (n % 100 == 0)
            sender_burst = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_LINES / 2)
            drain_results();
         send_line(random_line());
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d lines, checked %0d responses", lines_sent, sb.checked);
      $display("strengths 0..4 seen: %0d %0d %0d %0d %0d", sb.strength_seen[0],
               sb.strength_seen[1], sb.strength_seen[2], sb.strength_seen[3],
               sb.strength_seen[4]);
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/deblk_pkg.sv
hdl/deblk_channel_if.sv
hdl/deblk_strength.sv
hdl/deblk_filter.sv
hdl/deblock_edge_line_filter_core.sv
hdl/deblk_checker.sv
dv/tb_deblock_edge_line_filter_core.sv
